[rtl/core/tts_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tts_pkg
// Shared constants, slot record layout and helpers of the task table scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int TOT_W      = $clog2(SLOT_COUNT + 1);

  localparam int KIND_W  = 3;
  localparam int ID_W    = 16;
  localparam int PRIO_W  = 8;
  localparam int VIS_W   = 8;
  localparam int TICK_W  = 32;
  localparam int LIVE_W  = 4;
  localparam int PICK_W  = 3;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_READY   = 2'd1,
    ST_BLOCKED = 2'd2,
    ST_DELAYED = 2'd3
  } slot_state_e;

  typedef enum logic [KIND_W-1:0] {
    OP_CREATE  = 3'd0,
    OP_DESTROY = 3'd1,
    OP_DELAY   = 3'd2,
    OP_TICK    = 3'd3,
    OP_SCHED   = 3'd4
  } op_kind_e;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_SCAN,
    SQ_DONE
  } seq_state_e;

  typedef struct packed {
    slot_state_e         status;
    logic [ID_W-1:0]     ident;
    logic [PRIO_W-1:0]   prio;
    logic [VIS_W-1:0]    visits;
    logic [TICK_W-1:0]   countdown;
  } slot_rec_t;

  typedef struct packed {
    logic                we;
    logic [SLOT_W-1:0]   addr;
    slot_rec_t           data;
  } ram_wr_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [ID_W-1:0]     task_id;
    logic [PRIO_W-1:0]   task_priority;
    logic [TICK_W-1:0]   delay_ticks;
  } tts_req_t;

  typedef struct packed {
    logic                done;
    logic                ok;
    logic [LIVE_W-1:0]   live;
    logic [PICK_W-1:0]   picked;
    logic                none;
  } tts_res_t;

  function automatic logic [SLOT_W-1:0] next_slot(logic [SLOT_W-1:0] idx);
    return (idx == SLOT_W'(SLOT_COUNT - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [LIVE_W-1:0] live_of(logic [TOT_W-1:0] total);
    logic [TOT_W+LIVE_W-1:0] wide;
    wide = {{LIVE_W{1'b0}}, total};
    return wide[LIVE_W-1:0];
  endfunction

  function automatic logic [PICK_W-1:0] pick_of(logic [SLOT_W-1:0] idx);
    logic [SLOT_W+PICK_W-1:0] wide;
    wide = {{PICK_W{1'b0}}, idx};
    return wide[PICK_W-1:0];
  endfunction

endpackage
`default_nettype wire

[rtl/core/tts_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tts_in_if
// Request channel of the task table scheduler: valid/ready with one command.
// ----------------------------------------------------------------------------
interface tts_in_if;
  logic                        valid;
  logic                        ready;
  logic [tts_pkg::KIND_W-1:0]  kind;
  logic [tts_pkg::ID_W-1:0]    task_id;
  logic [tts_pkg::PRIO_W-1:0]  task_priority;
  logic [tts_pkg::TICK_W-1:0]  delay_ticks;

  modport source (output valid, output kind, output task_id, output task_priority,
                  output delay_ticks, input ready);
  modport sink   (input valid, input kind, input task_id, input task_priority,
                  input delay_ticks, output ready);
endinterface
`default_nettype wire

[rtl/core/tts_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tts_out_if
// Result channel of the task table scheduler: valid/ready with one result.
// ----------------------------------------------------------------------------
interface tts_out_if;
  logic                        valid;
  logic                        ready;
  logic                        op_ok;
  logic [tts_pkg::LIVE_W-1:0]  live_count;
  logic [tts_pkg::PICK_W-1:0]  picked_slot;
  logic                        none_ready;

  modport source (output valid, output op_ok, output live_count, output picked_slot,
                  output none_ready, input ready);
  modport sink   (input valid, input op_ok, input live_count, input picked_slot,
                  input none_ready, output ready);
endinterface
`default_nettype wire

[rtl/core/tts_slot_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tts_slot_ram
// Slot table memory: one write and one registered read per cycle, with a
// valid bit per entry so that an unwritten slot reads as a free, zero record.
// ----------------------------------------------------------------------------
module tts_slot_ram (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire tts_pkg::ram_wr_t            wr_i,
  input  wire logic [tts_pkg::SLOT_W-1:0]  raddr_i,
  output tts_pkg::slot_rec_t               rdata_o
);

  tts_pkg::slot_rec_t                  mem_q [tts_pkg::SLOT_COUNT];
  tts_pkg::slot_rec_t                  rd_q;
  logic [tts_pkg::SLOT_COUNT-1:0]      vld_q;
  logic                                rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.we) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      rd_vld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule
`default_nettype wire

[rtl/core/tts_seq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tts_seq
// Command sequencer: walks the slot table one entry per cycle through the
// memory, modifies entries on the fly and commits single-slot updates.
// ----------------------------------------------------------------------------
module tts_seq (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        req_valid_i,
  output logic                             req_ready_o,
  input  wire tts_pkg::tts_req_t           req_i,
  input  wire logic                        res_take_i,
  output tts_pkg::tts_res_t                res_o,
  output tts_pkg::ram_wr_t                 wr_o,
  output logic [tts_pkg::SLOT_W-1:0]       raddr_o,
  input  wire tts_pkg::slot_rec_t          rdata_i
);

  localparam int SW = tts_pkg::SLOT_W;
  localparam int TW = tts_pkg::TOT_W;

  tts_pkg::seq_state_e state_q, state_d;

  logic [tts_pkg::KIND_W-1:0] kind_q, kind_d;
  logic [tts_pkg::ID_W-1:0]   id_q, id_d;
  logic [tts_pkg::PRIO_W-1:0] prio_q, prio_d;
  logic [tts_pkg::TICK_W-1:0] ticks_q, ticks_d;

  logic          phase_q, phase_d;
  logic [SW-1:0] iss_idx_q, iss_idx_d;
  logic [TW-1:0] iss_cnt_q, iss_cnt_d;
  logic          p_vld_q, p_vld_d;
  logic [SW-1:0] p_idx_q, p_idx_d;
  logic          hit_q, hit_d;
  logic [SW-1:0] hit_idx_q, hit_idx_d;
  logic          dup_q, dup_d;
  logic          any_q, any_d;
  logic          found_q, found_d;
  tts_pkg::slot_rec_t hold_q, hold_d;

  logic [TW-1:0] total_q, total_d;
  logic [SW-1:0] cur_q, cur_d;
  logic [SW-1:0] scan_q, scan_d;

  logic          res_ok_q, res_ok_d;
  logic [SW-1:0] res_pick_q, res_pick_d;
  logic          res_none_q, res_none_d;

  logic          accept;
  logic          known_kind;
  logic          table_full;
  logic [TW-1:0] iss_lim;
  logic          sched_p2;
  logic          iss_en;
  logic          scan_end;
  logic          id_match;
  logic          do_proc;
  tts_pkg::slot_rec_t upd;

  assign accept     = (state_q == tts_pkg::SQ_IDLE) && req_valid_i;
  assign known_kind = (req_i.kind == tts_pkg::OP_CREATE) || (req_i.kind == tts_pkg::OP_DESTROY) ||
                      (req_i.kind == tts_pkg::OP_DELAY)  || (req_i.kind == tts_pkg::OP_TICK) ||
                      (req_i.kind == tts_pkg::OP_SCHED);
  assign table_full = (total_q >= TW'(tts_pkg::SLOT_COUNT));
  assign iss_lim    = (kind_q == tts_pkg::OP_DELAY) ? TW'(1) : TW'(tts_pkg::SLOT_COUNT);
  assign sched_p2   = (kind_q == tts_pkg::OP_SCHED) && phase_q;
  // the pick scan runs until a slot qualifies, other scans cover a fixed count
  assign iss_en     = (state_q == tts_pkg::SQ_SCAN) &&
                      (sched_p2 ? !found_q : (iss_cnt_q != iss_lim));
  assign scan_end   = (state_q == tts_pkg::SQ_SCAN) && !iss_en && !p_vld_q;
  // the read still in flight after a pick is dropped
  assign do_proc    = p_vld_q && !found_q;
  assign id_match   = (rdata_i.status != tts_pkg::ST_FREE) && (rdata_i.ident == id_q);
  assign raddr_o    = iss_idx_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tts_pkg::SQ_IDLE: begin
        if (req_valid_i) begin
          if (!known_kind || ((req_i.kind == tts_pkg::OP_CREATE) && table_full)) begin
            state_d = tts_pkg::SQ_DONE;
          end else begin
            state_d = tts_pkg::SQ_SCAN;
          end
        end
      end
      tts_pkg::SQ_SCAN: begin
        if (scan_end && !((kind_q == tts_pkg::OP_SCHED) && !phase_q && any_q)) begin
          state_d = tts_pkg::SQ_DONE;
        end
      end
      tts_pkg::SQ_DONE: begin
        if (res_take_i) begin
          state_d = tts_pkg::SQ_IDLE;
        end
      end
      default: state_d = tts_pkg::SQ_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    kind_d     = kind_q;
    id_d       = id_q;
    prio_d     = prio_q;
    ticks_d    = ticks_q;
    phase_d    = phase_q;
    iss_idx_d  = iss_idx_q;
    iss_cnt_d  = iss_cnt_q;
    p_vld_d    = iss_en;
    p_idx_d    = iss_idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    dup_d      = dup_q;
    any_d      = any_q;
    found_d    = found_q;
    hold_d     = hold_q;
    total_d    = total_q;
    cur_d      = cur_q;
    scan_d     = scan_q;
    res_ok_d   = res_ok_q;
    res_pick_d = res_pick_q;
    res_none_d = res_none_q;
    wr_o       = '0;
    upd        = rdata_i;

    req_ready_o = (state_q == tts_pkg::SQ_IDLE);

    res_o.done   = (state_q == tts_pkg::SQ_DONE) && res_take_i;
    res_o.ok     = res_ok_q;
    res_o.live   = tts_pkg::live_of(total_q);
    res_o.picked = tts_pkg::pick_of(res_pick_q);
    res_o.none   = res_none_q;

    if (accept) begin
      kind_d     = req_i.kind;
      id_d       = req_i.task_id;
      prio_d     = req_i.task_priority;
      ticks_d    = req_i.delay_ticks;
      phase_d    = 1'b0;
      iss_idx_d  = (req_i.kind == tts_pkg::OP_DELAY) ? cur_q : '0;
      iss_cnt_d  = '0;
      hit_d      = 1'b0;
      dup_d      = 1'b0;
      any_d      = 1'b0;
      found_d    = 1'b0;
      res_ok_d   = 1'b0;
      res_pick_d = '0;
      res_none_d = 1'b0;
    end

    if (iss_en) begin
      iss_idx_d = tts_pkg::next_slot(iss_idx_q);
      if (!sched_p2) begin
        iss_cnt_d = iss_cnt_q + 1'b1;
      end
    end

    if (do_proc) begin
      unique case (kind_q)
        tts_pkg::OP_CREATE: begin
          if (id_match) begin
            dup_d = 1'b1;
          end
          if ((rdata_i.status == tts_pkg::ST_FREE) && !hit_q) begin
            hit_d     = 1'b1;
            hit_idx_d = p_idx_q;
            hold_d    = rdata_i;
          end
        end
        tts_pkg::OP_DESTROY: begin
          if (id_match && !hit_q) begin
            hit_d     = 1'b1;
            hit_idx_d = p_idx_q;
            hold_d    = rdata_i;
          end
        end
        tts_pkg::OP_DELAY: begin
          if (rdata_i.status != tts_pkg::ST_FREE) begin
            upd.countdown = ticks_q;
            upd.status    = tts_pkg::ST_DELAYED;
            wr_o.we       = 1'b1;
            wr_o.addr     = p_idx_q;
            wr_o.data     = upd;
          end
        end
        tts_pkg::OP_TICK: begin
          if (rdata_i.status == tts_pkg::ST_DELAYED) begin
            upd.countdown = rdata_i.countdown - 1'b1;
            if (upd.countdown == '0) begin
              upd.status = tts_pkg::ST_READY;
            end
            wr_o.we   = 1'b1;
            wr_o.addr = p_idx_q;
            wr_o.data = upd;
          end
        end
        tts_pkg::OP_SCHED: begin
          if (!phase_q) begin
            if (rdata_i.status == tts_pkg::ST_READY) begin
              any_d = 1'b1;
            end
          end else begin
            // visit position is compared before its increment
            if ((rdata_i.status == tts_pkg::ST_READY) && (rdata_i.visits <= rdata_i.prio)) begin
              found_d   = 1'b1;
              hit_idx_d = p_idx_q;
            end
            upd.visits = rdata_i.visits + 1'b1;
            wr_o.we    = 1'b1;
            wr_o.addr  = p_idx_q;
            wr_o.data  = upd;
          end
        end
        default: ;
      endcase
    end

    // commit cycle: no read data is in flight, the write port is free
    if (scan_end) begin
      unique case (kind_q)
        tts_pkg::OP_CREATE: begin
          if (hit_q && !dup_q) begin
            upd        = hold_q;
            upd.status = tts_pkg::ST_READY;
            upd.ident  = id_q;
            upd.prio   = prio_q;
            wr_o.we    = 1'b1;
            wr_o.addr  = hit_idx_q;
            wr_o.data  = upd;
            total_d    = total_q + 1'b1;
            res_ok_d   = 1'b1;
          end
        end
        tts_pkg::OP_DESTROY: begin
          if (hit_q && (hit_idx_q != cur_q)) begin
            upd        = hold_q;
            upd.status = tts_pkg::ST_FREE;
            upd.ident  = '0;
            upd.visits = '0;
            wr_o.we    = 1'b1;
            wr_o.addr  = hit_idx_q;
            wr_o.data  = upd;
            if (total_q != '0) begin
              total_d = total_q - 1'b1;
            end
            res_ok_d = 1'b1;
          end
        end
        tts_pkg::OP_SCHED: begin
          if (!phase_q) begin
            if (!any_q) begin
              res_none_d = 1'b1;
            end else begin
              phase_d   = 1'b1;
              iss_idx_d = tts_pkg::next_slot(scan_q);
            end
          end else begin
            cur_d      = hit_idx_q;
            scan_d     = hit_idx_q;
            res_ok_d   = 1'b1;
            res_pick_d = hit_idx_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tts_pkg::SQ_IDLE;
      phase_q    <= 1'b0;
      iss_idx_q  <= '0;
      iss_cnt_q  <= '0;
      p_vld_q    <= 1'b0;
      hit_q      <= 1'b0;
      dup_q      <= 1'b0;
      any_q      <= 1'b0;
      found_q    <= 1'b0;
      total_q    <= '0;
      cur_q      <= '0;
      scan_q     <= SW'(tts_pkg::SLOT_COUNT - 1);
      res_ok_q   <= 1'b0;
      res_pick_q <= '0;
      res_none_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      iss_idx_q  <= iss_idx_d;
      iss_cnt_q  <= iss_cnt_d;
      p_vld_q    <= p_vld_d;
      hit_q      <= hit_d;
      dup_q      <= dup_d;
      any_q      <= any_d;
      found_q    <= found_d;
      total_q    <= total_d;
      cur_q      <= cur_d;
      scan_q     <= scan_d;
      res_ok_q   <= res_ok_d;
      res_pick_q <= res_pick_d;
      res_none_q <= res_none_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    id_q      <= id_d;
    prio_q    <= prio_d;
    ticks_q   <= ticks_d;
    p_idx_q   <= p_idx_d;
    hit_idx_q <= hit_idx_d;
    hold_q    <= hold_d;
  end

endmodule
`default_nettype wire

[rtl/core/task_table_scheduler_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// task_table_scheduler_core
// Task slot table with create, destroy, delay, tick and round-robin
// priority scheduling, one command item in and one result item out.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  in_i     | in  | valid / ready | kind, task_id, task_priority, delay_ticks
//  out_o    | out | valid / ready | op_ok, live_count, picked_slot, none_ready
//
// create, destroy, tick: one memory read per slot; delay: the current slot only;
// unknown kind or create on a full table: no memory read, straight to the result
// schedule: a readiness scan of every slot, then a pick scan until a slot
// qualifies (only the readiness scan when no slot is ready)
// the slot memory has a single read port; reset needs no clearing pass
// one item is in work at a time; a result waits in the output register while
// the next item is taken, and the sequencer holds its result if out_o stalls
module task_table_scheduler_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tts_in_if.sink     in_i,
  tts_out_if.source  out_o
);

  tts_pkg::tts_req_t  req;
  tts_pkg::tts_res_t  res;
  tts_pkg::ram_wr_t   wr;
  tts_pkg::slot_rec_t rdata;
  logic [tts_pkg::SLOT_W-1:0] raddr;
  logic req_ready;
  logic res_take;

  logic                        out_vld_q;
  logic                        out_ok_q;
  logic [tts_pkg::LIVE_W-1:0]  out_live_q;
  logic [tts_pkg::PICK_W-1:0]  out_pick_q;
  logic                        out_none_q;

  assign req.kind          = in_i.kind;
  assign req.task_id       = in_i.task_id;
  assign req.task_priority = in_i.task_priority;
  assign req.delay_ticks   = in_i.delay_ticks;
  assign in_i.ready        = req_ready;

  assign res_take = !out_vld_q || out_o.ready;

  tts_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_i.valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .res_take_i  (res_take),
    .res_o       (res),
    .wr_o        (wr),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  tts_slot_ram u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res.done) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.done) begin
      out_ok_q   <= res.ok;
      out_live_q <= res.live;
      out_pick_q <= res.picked;
      out_none_q <= res.none;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.op_ok       = out_ok_q;
  assign out_o.live_count  = out_live_q;
  assign out_o.picked_slot = out_pick_q;
  assign out_o.none_ready  = out_none_q;

`ifndef SYNTHESIS
  // a result is handed over only when the output register can take it
  a_done_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.done |-> (!out_vld_q || out_o.ready))
    else $error("result produced while output register is occupied");

  // a schedule either picks a slot or reports none ready, never both
  a_ok_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.done |-> !(res.ok && res.none))
    else $error("result reports success and none ready together");

  // an accepted item keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("new item taken right after an accept");
`endif

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the task table scheduler core. A queued driver
// feeds create, destroy, delay, tick, schedule and reserved-kind items, and a slot-table
// predictor computes each expected result. The monitor compares every
// result item field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int  TAIL_ITEMS   = 200;
  localparam int  RANDOM_ITEMS = 1800;
  localparam int  POOL_SIZE    = 12;
  localparam int  DRAIN_AT     = 900;
  localparam longint TIMEOUT_NS = 64'd60_000_000;

  localparam logic [tts_pkg::KIND_W-1:0] KIND_RSVD_A = 3'd5;
  localparam logic [tts_pkg::KIND_W-1:0] KIND_RSVD_B = 3'd6;
  localparam logic [tts_pkg::KIND_W-1:0] KIND_RSVD_C = 3'd7;

  typedef struct {
    logic [tts_pkg::KIND_W-1:0] kind;
    logic [tts_pkg::ID_W-1:0]   task_id;
    logic [tts_pkg::PRIO_W-1:0] task_priority;
    logic [tts_pkg::TICK_W-1:0] delay_ticks;
    bit                         drain;
  } sched_cmd_t;

  typedef struct {
    logic                       op_ok;
    logic [tts_pkg::LIVE_W-1:0] live_count;
    logic [tts_pkg::PICK_W-1:0] picked_slot;
    logic                       none_ready;
  } sched_res_t;

  logic clk_i;
  logic rst_ni;

  tts_in_if  in_if ();
  tts_out_if out_if ();

  task_table_scheduler_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // slot table as the predictor sees it
  tts_pkg::slot_state_e       tbl_state  [tts_pkg::SLOT_COUNT];
  logic [tts_pkg::ID_W-1:0]   tbl_ident  [tts_pkg::SLOT_COUNT];
  logic [tts_pkg::PRIO_W-1:0] tbl_prio   [tts_pkg::SLOT_COUNT];
  logic [tts_pkg::VIS_W-1:0]  tbl_visits [tts_pkg::SLOT_COUNT];
  logic [tts_pkg::TICK_W-1:0] tbl_count  [tts_pkg::SLOT_COUNT];
  int                         live_tasks;
  int                         running_slot;
  int                         last_pick;

  sched_cmd_t  pending_cmds [$];
  sched_res_t  expected_results [$];
  logic [tts_pkg::ID_W-1:0] id_pool [POOL_SIZE];

  sched_cmd_t  cur_cmd;
  sched_res_t  got_res;
  sched_res_t  want_res;
  int          mismatches;
  int          items_sent;
  int          gap_left;
  int          stall_left;
  int          idle_pct;
  int          stall_pct;

  function automatic int find_live_task(logic [tts_pkg::ID_W-1:0] id);
    int hit;
    hit = -1;
    for (int i = tts_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
      if (tbl_state[i] != tts_pkg::ST_FREE && tbl_ident[i] == id) hit = i;
    end
    return hit;
  endfunction

  function automatic sched_res_t predict_result(sched_cmd_t c);
    sched_res_t r;
    int         hit;
    int         pos;
    bit         any_ready;
    bit         found;
    r.op_ok       = 1'b0;
    r.picked_slot = '0;
    r.none_ready  = 1'b0;
    case (c.kind)
      tts_pkg::OP_CREATE: begin
        if (live_tasks < tts_pkg::SLOT_COUNT && find_live_task(c.task_id) < 0) begin
          found = 1'b0;
          for (int i = 0; i < tts_pkg::SLOT_COUNT; i++) begin
            if (!found && tbl_state[i] == tts_pkg::ST_FREE) begin
              // visit position and countdown keep their old values
              tbl_state[i] = tts_pkg::ST_READY;
              tbl_ident[i] = c.task_id;
              tbl_prio[i]  = c.task_priority;
              live_tasks++;
              r.op_ok = 1'b1;
              found   = 1'b1;
            end
          end
        end
      end
      tts_pkg::OP_DESTROY: begin
        hit = find_live_task(c.task_id);
        if (hit >= 0 && hit != running_slot) begin
          tbl_state[hit]  = tts_pkg::ST_FREE;
          tbl_ident[hit]  = '0;
          tbl_visits[hit] = '0;
          if (live_tasks > 0) live_tasks--;
          r.op_ok = 1'b1;
        end
      end
      tts_pkg::OP_DELAY: begin
        if (tbl_state[running_slot] != tts_pkg::ST_FREE) begin
          tbl_count[running_slot] = c.delay_ticks;
          tbl_state[running_slot] = tts_pkg::ST_DELAYED;
        end
      end
      tts_pkg::OP_TICK: begin
        for (int i = 0; i < tts_pkg::SLOT_COUNT; i++) begin
          if (tbl_state[i] == tts_pkg::ST_DELAYED) begin
            tbl_count[i] = tbl_count[i] - 1'b1;
            if (tbl_count[i] == '0) tbl_state[i] = tts_pkg::ST_READY;
          end
        end
      end
      tts_pkg::OP_SCHED: begin
        any_ready = 1'b0;
        for (int i = 0; i < tts_pkg::SLOT_COUNT; i++) begin
          if (tbl_state[i] == tts_pkg::ST_READY) any_ready = 1'b1;
        end
        if (!any_ready) begin
          r.none_ready = 1'b1;
        end else begin
          // visit position is compared before it is bumped
          pos   = last_pick;
          found = 1'b0;
          while (!found) begin
            pos = (pos == tts_pkg::SLOT_COUNT - 1) ? 0 : pos + 1;
            if (tbl_state[pos] == tts_pkg::ST_READY && tbl_visits[pos] <= tbl_prio[pos]) begin
              found         = 1'b1;
              r.picked_slot = tts_pkg::PICK_W'(pos);
              last_pick     = pos;
              running_slot  = pos;
            end
            tbl_visits[pos] = tbl_visits[pos] + 1'b1;
          end
          r.op_ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.live_count = tts_pkg::LIVE_W'(live_tasks);
    return r;
  endfunction

  task automatic add_cmd(logic [tts_pkg::KIND_W-1:0] kind, logic [tts_pkg::ID_W-1:0] id,
                         logic [tts_pkg::PRIO_W-1:0] prio,
                         logic [tts_pkg::TICK_W-1:0] ticks);
    sched_cmd_t c;
    c.kind          = kind;
    c.task_id       = id;
    c.task_priority = prio;
    c.delay_ticks   = ticks;
    c.drain         = 1'b0;
    pending_cmds.push_back(c);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_top failed");
    $finish;
  end

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_results.push_back(predict_result(cur_cmd));
        items_sent++;
        if (items_sent % 64 == 0) begin
          case ($urandom_range(2))
            0: idle_pct = 0;
            1: idle_pct = 20;
            default: idle_pct = 50;
          endcase
          case ($urandom_range(2))
            0: stall_pct = 0;
            1: stall_pct = 20;
            default: stall_pct = 50;
          endcase
        end
        if (pending_cmds.size() > TAIL_ITEMS && $urandom_range(99) < idle_pct)
          gap_left = $urandom_range(1, 6);
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_cmds.size() != 0 &&
                     !(pending_cmds[0].drain && expected_results.size() != 0)) begin
          cur_cmd = pending_cmds.pop_front();
          in_if.valid         <= 1'b1;
          in_if.kind          <= cur_cmd.kind;
          in_if.task_id       <= cur_cmd.task_id;
          in_if.task_priority <= cur_cmd.task_priority;
          in_if.delay_ticks   <= cur_cmd.delay_ticks;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got_res.op_ok       = out_if.op_ok;
        got_res.live_count  = out_if.live_count;
        got_res.picked_slot = out_if.picked_slot;
        got_res.none_ready  = out_if.none_ready;
        if (expected_results.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result item: ok=%0b live=%0d pick=%0d none=%0b",
                     got_res.op_ok, got_res.live_count, got_res.picked_slot,
                     got_res.none_ready);
          mismatches++;
        end else begin
          want_res = expected_results.pop_front();
          if (got_res.op_ok !== want_res.op_ok ||
              got_res.live_count !== want_res.live_count ||
              got_res.picked_slot !== want_res.picked_slot ||
              got_res.none_ready !== want_res.none_ready) begin
            if (mismatches < 10)
              $display({"mismatch: exp ok=%0b live=%0d pick=%0d none=%0b,",
                        " got ok=%0b live=%0d pick=%0d none=%0b"},
                       want_res.op_ok, want_res.live_count, want_res.picked_slot,
                       want_res.none_ready, got_res.op_ok, got_res.live_count,
                       got_res.picked_slot, got_res.none_ready);
            mismatches++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (pending_cmds.size() > TAIL_ITEMS && $urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(0, 5);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    sched_cmd_t c;
    int         r;
    in_if.valid         = 1'b0;
    in_if.kind          = '0;
    in_if.task_id       = '0;
    in_if.task_priority = '0;
    in_if.delay_ticks   = '0;
    out_if.ready        = 1'b0;
    rst_ni       = 1'b0;
    mismatches   = 0;
    items_sent   = 0;
    gap_left     = 0;
    stall_left   = 0;
    idle_pct     = 30;
    stall_pct    = 30;
    live_tasks   = 0;
    running_slot = 0;
    last_pick    = tts_pkg::SLOT_COUNT - 1;
    for (int i = 0; i < tts_pkg::SLOT_COUNT; i++) begin
      tbl_state[i]  = tts_pkg::ST_FREE;
      tbl_ident[i]  = '0;
      tbl_prio[i]   = '0;
      tbl_visits[i] = '0;
      tbl_count[i]  = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = tts_pkg::ID_W'($urandom);
    id_pool[0] = '0;
    id_pool[1] = '1;

    // directed part
    add_cmd(tts_pkg::OP_DELAY, 16'h0000, 8'h00, 32'd5);      // current slot still free
    add_cmd(tts_pkg::OP_SCHED, 16'h0000, 8'h00, 32'd0);      // nothing ready
    add_cmd(KIND_RSVD_A, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    add_cmd(KIND_RSVD_B, 16'h0000, 8'h00, 32'h0000_0000);
    add_cmd(KIND_RSVD_C, 16'h5A5A, 8'hA5, 32'h5A5A_A5A5);
    add_cmd(tts_pkg::OP_CREATE, id_pool[0], 8'h00, 32'd0);   // id zero vs free slots
    add_cmd(tts_pkg::OP_CREATE, id_pool[0], 8'hFF, 32'd0);   // duplicate
    add_cmd(tts_pkg::OP_CREATE, id_pool[1], 8'hFF, 32'd0);
    add_cmd(tts_pkg::OP_DESTROY, id_pool[0], 8'h00, 32'd0);  // current task
    add_cmd(tts_pkg::OP_DESTROY, id_pool[11], 8'h00, 32'd0); // unknown id
    add_cmd(tts_pkg::OP_SCHED, 16'h0000, 8'h00, 32'd0);
    add_cmd(tts_pkg::OP_DELAY, 16'h0000, 8'h00, 32'd0);      // zero wraps on tick
    add_cmd(tts_pkg::OP_TICK, 16'h0000, 8'h00, 32'd0);
    add_cmd(tts_pkg::OP_SCHED, 16'h0000, 8'h00, 32'd0);
    add_cmd(tts_pkg::OP_DELAY, 16'h0000, 8'h00, 32'd1);
    add_cmd(tts_pkg::OP_TICK, 16'h0000, 8'h00, 32'd0);
    add_cmd(tts_pkg::OP_SCHED, 16'h0000, 8'h00, 32'd0);
    add_cmd(tts_pkg::OP_DESTROY, id_pool[0], 8'h00, 32'd0);
    for (int i = 2; i < 9; i++)
      add_cmd(tts_pkg::OP_CREATE, id_pool[i], (i % 2 == 0) ? 8'h00 : 8'hFF, 32'd0);
    add_cmd(tts_pkg::OP_CREATE, id_pool[10], 8'h80, 32'd0);  // table full
    add_cmd(tts_pkg::OP_SCHED, 16'h0000, 8'h00, 32'd0);
    add_cmd(tts_pkg::OP_DELAY, 16'h0000, 8'h00, 32'hFFFF_FFFF);
    add_cmd(tts_pkg::OP_SCHED, 16'h0000, 8'h00, 32'd0);

    // random part
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      c.task_id       = tts_pkg::ID_W'($urandom);
      c.task_priority = tts_pkg::PRIO_W'($urandom);
      c.delay_ticks   = $urandom;
      c.drain         = (n == 0 || n == DRAIN_AT);
      r = $urandom_range(99);
      if (r < 20) begin
        c.kind    = tts_pkg::OP_CREATE;
        c.task_id = id_pool[$urandom_range(POOL_SIZE - 1)];
        r = $urandom_range(99);
        // mostly high priorities keep the pick scan short
        if (r < 70)      c.task_priority = tts_pkg::PRIO_W'($urandom_range(128, 255));
        else if (r < 90) c.task_priority = tts_pkg::PRIO_W'($urandom_range(255));
        else             c.task_priority = tts_pkg::PRIO_W'($urandom_range(3));
      end else if (r < 33) begin
        c.kind = tts_pkg::OP_DESTROY;
        if ($urandom_range(99) < 92) c.task_id = id_pool[$urandom_range(POOL_SIZE - 1)];
      end else if (r < 45) begin
        c.kind = tts_pkg::OP_DELAY;
        r = $urandom_range(99);
        if (r < 80)      c.delay_ticks = $urandom_range(1, 6);
        else if (r < 86) c.delay_ticks = '0;
        else if (r < 90) c.delay_ticks = '1;
      end else if (r < 67) begin
        c.kind = tts_pkg::OP_TICK;
      end else if (r < 96) begin
        c.kind = tts_pkg::OP_SCHED;
      end else begin
        c.kind = tts_pkg::KIND_W'($urandom_range(KIND_RSVD_A, KIND_RSVD_C));
      end
      pending_cmds.push_back(c);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || in_if.valid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
